// File: rtl/fxalu_pkg.sv
// Package with the command codes and default sizes of the Q24.8 fixed-point ALU.
package fxalu_pkg;

  localparam int DefWordBits = 32;
  localparam int DefFracBits = 8;
  localparam int CmdBits     = 4;

  typedef enum logic [CmdBits-1:0] {
    CmdAdd     = 4'd0,
    CmdSub     = 4'd1,
    CmdMul     = 4'd2,
    CmdDiv     = 4'd3,
    CmdMin     = 4'd4,
    CmdMax     = 4'd5,
    CmdInc     = 4'd6,
    CmdDec     = 4'd7,
    CmdToInt   = 4'd8,
    CmdCompare = 4'd9,
    CmdFromInt = 4'd10
  } cmd_e;

endpackage

// File: rtl/fixed_point_q24_8_alu.sv
// Pipelined signed fixed-point ALU with a rounding, saturating multiplier and a pipelined divider.
//
//   Channel   Handshake            Payload
//   command   start_i / busy_o     command_i, operand_a_i, operand_b_i
//   result    done_o (strobe)      result_value_o, is_less_o, is_equal_o, is_greater_o,
//                                  overflow_o, divide_by_zero_o
//
// Every transaction passes through the stage registers st_q and then the output
// registers; the divider resolves one quotient bit per stage.
// A new transaction is accepted in every cycle, so busy_o stays low.
// Reset clears only the valid bits of the pipeline, so no result leaves after reset.
// The receiver cannot stall, and each result is shown for exactly one cycle.
module fixed_point_q24_8_alu #(
  parameter int WordBits = fxalu_pkg::DefWordBits,
  parameter int FracBits = fxalu_pkg::DefFracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [fxalu_pkg::CmdBits-1:0] command_i,
  input  logic signed [WordBits-1:0]   operand_a_i,
  input  logic signed [WordBits-1:0]   operand_b_i,
  output logic                         done_o,
  output logic signed [WordBits-1:0]   result_value_o,
  output logic                         is_less_o,
  output logic                         is_equal_o,
  output logic                         is_greater_o,
  output logic                         overflow_o,
  output logic                         divide_by_zero_o
);

  localparam int W  = WordBits;
  localparam int F  = FracBits;
  localparam int NW = W + F;
  localparam int D  = NW;
  localparam int QW = 2 * W + 1;
  localparam int HL = (W + 1) / 2;
  localparam int HH = W - HL;

  typedef struct packed {
    fxalu_pkg::cmd_e cmd;
    logic            neg;
    logic [W-1:0]    res;
    logic            lt;
    logic            eq;
    logic            gt;
    logic            ovf;
    logic [W-1:0]    div;
    logic [W:0]      rem;
    logic [NW-1:0]   nq;
    logic [W-1:0]    mres;
    logic            movf;
  } stage_t;

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    return x[W-1] ? (~x + W'(1)) : x;
  endfunction

  function automatic logic [W:0] sat(input logic neg, input logic [QW-1:0] q);
    logic [QW-1:0] lim;
    logic          ovf;
    logic [W-1:0]  m;
    lim = neg ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
    ovf = q > lim;
    m   = ovf ? lim[W-1:0] : q[W-1:0];
    return {ovf, neg ? (~m + W'(1)) : m};
  endfunction

  logic                 accept;
  stage_t               st_d [D+1];
  stage_t               st_q [D+1];
  logic [D:0]           vld_q;
  logic [2*HL-1:0]      pp0_q;
  logic [HL+HH-1:0]     pp1_q;
  logic [HL+HH-1:0]     pp2_q;
  logic [2*HH-1:0]      pp3_q;
  logic [2*W-1:0]       prod_q;
  logic [W-1:0]         res_d;
  logic                 lt_d;
  logic                 eq_d;
  logic                 gt_d;
  logic                 ovf_d;
  logic                 dz_d;
  logic [W-1:0]         res_q;
  logic                 lt_q;
  logic                 eq_q;
  logic                 gt_q;
  logic                 ovf_q;
  logic                 dz_q;
  logic                 done_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    logic [W-1:0]  a;
    logic [W-1:0]  b;
    logic [W-1:0]  s;
    logic [W-1:0]  fi;
    logic          slt;
    logic          sgt;
    logic [W:0]    rs;
    logic          ge;
    logic [QW-1:0] rp;
    logic [W:0]    fin;
    a   = operand_a_i;
    b   = operand_b_i;
    s   = '0;
    slt = $signed(a) < $signed(b);
    sgt = $signed(b) < $signed(a);
    fi  = a << F;
    st_d[0]      = '0;
    st_d[0].cmd  = fxalu_pkg::cmd_e'(command_i);
    st_d[0].neg  = a[W-1] ^ b[W-1];
    st_d[0].div  = mag(b);
    st_d[0].nq   = {mag(a), F'(0)};
    unique case (fxalu_pkg::cmd_e'(command_i))
      fxalu_pkg::CmdAdd: begin
        s = a + b;
        st_d[0].res = s;
        st_d[0].ovf = (a[W-1] == b[W-1]) && (s[W-1] != a[W-1]);
      end
      fxalu_pkg::CmdSub: begin
        s = a - b;
        st_d[0].res = s;
        st_d[0].ovf = (a[W-1] != b[W-1]) && (s[W-1] != a[W-1]);
      end
      fxalu_pkg::CmdMin: st_d[0].res = sgt ? b : a;
      fxalu_pkg::CmdMax: st_d[0].res = slt ? b : a;
      fxalu_pkg::CmdInc: begin
        st_d[0].res = a + W'(1);
        st_d[0].ovf = a == {1'b0, {(W-1){1'b1}}};
      end
      fxalu_pkg::CmdDec: begin
        st_d[0].res = a - W'(1);
        st_d[0].ovf = a == {1'b1, {(W-1){1'b0}}};
      end
      fxalu_pkg::CmdToInt: st_d[0].res = $signed(a) >>> F;
      fxalu_pkg::CmdCompare: begin
        st_d[0].lt = slt;
        st_d[0].gt = sgt;
        st_d[0].eq = a == b;
      end
      fxalu_pkg::CmdFromInt: begin
        st_d[0].res = fi;
        st_d[0].ovf = W'($signed(fi) >>> F) != a;
      end
      default: st_d[0].res = '0;
    endcase
    rp  = {1'b0, prod_q} + (QW'(1) << (F - 1));
    fin = sat(st_q[2].neg, rp >> F);
    for (int k = 1; k <= D; k++) begin
      st_d[k]     = st_q[k-1];
      rs          = {st_q[k-1].rem[W-1:0], st_q[k-1].nq[NW-1]};
      ge          = rs >= {1'b0, st_q[k-1].div};
      st_d[k].rem = ge ? (rs - {1'b0, st_q[k-1].div}) : rs;
      st_d[k].nq  = {st_q[k-1].nq[NW-2:0], ge};
      if (k == 3) begin
        st_d[k].mres = fin[W-1:0];
        st_d[k].movf = fin[W];
      end
    end
  end

  always_comb begin
    logic          rnd;
    logic [W:0]    fin;
    rnd   = {st_q[D].rem, 1'b0} >= {2'b00, st_q[D].div};
    fin   = sat(st_q[D].neg, QW'(st_q[D].nq) + QW'(rnd));
    res_d = st_q[D].res;
    lt_d  = st_q[D].lt;
    eq_d  = st_q[D].eq;
    gt_d  = st_q[D].gt;
    ovf_d = st_q[D].ovf;
    dz_d  = 1'b0;
    if (st_q[D].cmd == fxalu_pkg::CmdMul) begin
      res_d = st_q[D].mres;
      ovf_d = st_q[D].movf;
    end else if (st_q[D].cmd == fxalu_pkg::CmdDiv) begin
      if (st_q[D].div == '0) begin
        res_d = '0;
        dz_d  = 1'b1;
        ovf_d = 1'b0;
      end else begin
        res_d = fin[W-1:0];
        ovf_d = fin[W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= {vld_q[D-1:0], accept};
      done_q <= vld_q[D];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= D; k++) begin
      st_q[k] <= st_d[k];
    end
    pp0_q  <= st_q[0].nq[F+HL-1:F] * st_q[0].div[HL-1:0];
    pp1_q  <= st_q[0].nq[F+HL-1:F] * st_q[0].div[W-1:HL];
    pp2_q  <= st_q[0].nq[NW-1:F+HL] * st_q[0].div[HL-1:0];
    pp3_q  <= st_q[0].nq[NW-1:F+HL] * st_q[0].div[W-1:HL];
    prod_q <= (2*W)'(pp0_q) + ((2*W)'(pp1_q) << HL) + ((2*W)'(pp2_q) << HL)
            + ((2*W)'(pp3_q) << (2 * HL));
    res_q  <= res_d;
    lt_q   <= lt_d;
    eq_q   <= eq_d;
    gt_q   <= gt_d;
    ovf_q  <= ovf_d;
    dz_q   <= dz_d;
  end

  assign done_o           = done_q;
  assign result_value_o   = res_q;
  assign is_less_o        = lt_q;
  assign is_equal_o       = eq_q;
  assign is_greater_o     = gt_q;
  assign overflow_o       = ovf_q;
  assign divide_by_zero_o = dz_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> ##(D+1) done_o)
    else $error("Accepted transaction did not complete at the pipeline depth.");

  a_cmp_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $onehot0({is_less_o, is_equal_o, is_greater_o}))
    else $error("More than one compare flag is set.");

  a_dz_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && divide_by_zero_o |-> result_value_o == '0 && !overflow_o)
    else $error("Divide by zero left a nonzero result or an overflow.");

  a_cmp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (is_less_o || is_equal_o || is_greater_o) |->
      result_value_o == '0 && !overflow_o)
    else $error("Compare produced a nonzero result.");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the Q24.8 fixed-point ALU with a bursty command driver.
module tb_top;

  typedef struct packed {
    logic [fxalu_pkg::CmdBits-1:0] cmd;
    logic [31:0]                   a;
    logic [31:0]                   b;
    logic                          drain;
  } alu_cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        ovf;
    logic        dz;
  } alu_res_t;

  localparam int unsigned MaxCycles = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [fxalu_pkg::CmdBits-1:0] command_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic done_o;
  logic signed [31:0] result_value_o;
  logic is_less_o, is_equal_o, is_greater_o, overflow_o, divide_by_zero_o;

  alu_cmd_t    cmd_queue[$];
  alu_res_t    result_queue[$];
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned issued = 0;
  int unsigned cycles = 0;
  int unsigned cmd_count[16];
  int          gap_left = 0;
  int          burst_left = 4;

  fixed_point_q24_8_alu dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .command_i, .operand_a_i, .operand_b_i,
    .done_o, .result_value_o, .is_less_o, .is_equal_o, .is_greater_o,
    .overflow_o, .divide_by_zero_o
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [31:0] signed_saturate(bit neg, longint unsigned mag,
                                                  inout logic ovf);
    longint unsigned lim;
    lim = neg ? 64'h8000_0000 : 64'h7fff_ffff;
    if (mag > lim) begin
      ovf = 1'b1;
      mag = lim;
    end
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  function automatic alu_res_t alu_predict(alu_cmd_t c);
    alu_res_t r;
    longint signed sa, sb;
    longint unsigned ma, mb, q, rem;
    bit neg;
    r = '0;
    sa = longint'($signed(c.a));
    sb = longint'($signed(c.b));
    ma = (sa < 0) ? -sa : sa;
    mb = (sb < 0) ? -sb : sb;
    neg = c.a[31] ^ c.b[31];
    case (c.cmd)
      fxalu_pkg::CmdAdd: begin
        r.value = c.a + c.b;
        r.ovf = (c.a[31] == c.b[31]) && (r.value[31] != c.a[31]);
      end
      fxalu_pkg::CmdSub: begin
        r.value = c.a - c.b;
        r.ovf = (c.a[31] != c.b[31]) && (r.value[31] != c.a[31]);
      end
      fxalu_pkg::CmdMul: begin
        q = (ma * mb + 64'd128) >> 8;
        r.value = signed_saturate(neg, q, r.ovf);
      end
      fxalu_pkg::CmdDiv: begin
        if (c.b == 0) begin
          r.dz = 1'b1;
        end else begin
          q = (ma << 8) / mb;
          rem = (ma << 8) % mb;
          if (2 * rem >= mb) q++;
          r.value = signed_saturate(neg, q, r.ovf);
        end
      end
      fxalu_pkg::CmdMin: r.value = (sb < sa) ? c.b : c.a;
      fxalu_pkg::CmdMax: r.value = (sa < sb) ? c.b : c.a;
      fxalu_pkg::CmdInc: begin
        r.value = c.a + 1;
        r.ovf = (c.a == 32'h7fff_ffff);
      end
      fxalu_pkg::CmdDec: begin
        r.value = c.a - 1;
        r.ovf = (c.a == 32'h8000_0000);
      end
      fxalu_pkg::CmdToInt: r.value = $signed(c.a) >>> 8;
      fxalu_pkg::CmdCompare: begin
        r.lt = sa < sb;
        r.eq = sa == sb;
        r.gt = sa > sb;
      end
      fxalu_pkg::CmdFromInt: begin
        r.value = c.a << 8;
        r.ovf = (longint'($signed(r.value) >>> 8) != sa);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 2047) - 1024;
      2: return 32'h7fff_ffff - $urandom_range(0, 3);
      3: return 32'h8000_0000 + $urandom_range(0, 3);
      4: return $urandom_range(0, 65535) << $urandom_range(0, 16);
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic add_cmd(logic [fxalu_pkg::CmdBits-1:0] c, logic [31:0] a,
                         logic [31:0] b);
    cmd_queue.push_back('{cmd: c, a: a, b: b, drain: 1'b0});
  endtask

  // Driver: accepts on start && !busy, then offers the next command in bursts.
  always @(posedge clk_i or negedge rst_ni) begin
    alu_cmd_t nxt;
    logic     next_start;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      next_start = start_i;
      if (start_i && !busy_o) begin
        result_queue.push_back(alu_predict('{cmd: command_i, a: operand_a_i,
                                             b: operand_b_i, drain: 1'b0}));
        cmd_count[command_i]++;
        issued++;
        next_start = 1'b0;
      end
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() > 0 &&
                     (!cmd_queue[0].drain || result_queue.size() == 0)) begin
          nxt = cmd_queue.pop_front();
          command_i <= nxt.cmd;
          operand_a_i <= nxt.a;
          operand_b_i <= nxt.b;
          next_start = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
          end
        end
      end
      start_i <= next_start;
    end
  end

  // Monitor: results arrive in order, one per strobe.
  always @(posedge clk_i) begin
    alu_res_t got, exp_res;
    if (rst_ni && done_o) begin
      got = '{value: result_value_o, lt: is_less_o, eq: is_equal_o, gt: is_greater_o,
              ovf: overflow_o, dz: divide_by_zero_o};
      if (result_queue.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_res = result_queue.pop_front();
        checked++;
        if (got !== exp_res) begin
          $display("%0t: mismatch value exp %h got %h, lt/eq/gt/ovf/dz exp %b got %b",
                   $time, exp_res.value, got.value, exp_res[4:0], got[4:0]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MaxCycles) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycles,
               result_queue.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n;
    add_cmd(fxalu_pkg::CmdAdd, 32'h7fff_ffff, 32'h1);
    add_cmd(fxalu_pkg::CmdAdd, 32'h8000_0000, 32'hffff_ffff);
    add_cmd(fxalu_pkg::CmdSub, 32'h8000_0000, 32'h1);
    add_cmd(fxalu_pkg::CmdSub, 32'h7fff_ffff, 32'h8000_0000);
    add_cmd(fxalu_pkg::CmdMul, 32'h7fff_ffff, 32'h7fff_ffff);
    add_cmd(fxalu_pkg::CmdMul, 32'h8000_0000, 32'h8000_0000);
    add_cmd(fxalu_pkg::CmdMul, 32'h8000_0000, 32'h100);
    add_cmd(fxalu_pkg::CmdMul, 32'h1, 32'h80);
    add_cmd(fxalu_pkg::CmdMul, 32'hffff_ffff, 32'h80);
    add_cmd(fxalu_pkg::CmdDiv, 32'h100, 32'h0);
    add_cmd(fxalu_pkg::CmdDiv, 32'h8000_0000, 32'hffff_ffff);
    add_cmd(fxalu_pkg::CmdDiv, 32'h100, 32'h300);
    add_cmd(fxalu_pkg::CmdDiv, 32'hffff_ff00, 32'h200);
    add_cmd(fxalu_pkg::CmdMin, 32'h8000_0000, 32'h7fff_ffff);
    add_cmd(fxalu_pkg::CmdMax, 32'h8000_0000, 32'h7fff_ffff);
    add_cmd(fxalu_pkg::CmdMin, 32'h5, 32'h5);
    add_cmd(fxalu_pkg::CmdInc, 32'h7fff_ffff, 32'h0);
    add_cmd(fxalu_pkg::CmdDec, 32'h8000_0000, 32'h0);
    add_cmd(fxalu_pkg::CmdToInt, 32'hffff_ff01, 32'h0);
    add_cmd(fxalu_pkg::CmdCompare, 32'h8000_0000, 32'h7fff_ffff);
    add_cmd(fxalu_pkg::CmdCompare, 32'h1234, 32'h1234);
    add_cmd(fxalu_pkg::CmdCompare, 32'h7fff_ffff, 32'hffff_ffff);
    add_cmd(fxalu_pkg::CmdFromInt, 32'h0080_0000, 32'h0);
    add_cmd(fxalu_pkg::CmdFromInt, 32'hff80_0000, 32'h0);
    add_cmd(4'd15, 32'hffff_ffff, 32'hffff_ffff);
    for (n = 0; n < 600; n++) begin
      add_cmd(($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15))
                                          : 4'($urandom_range(0, 10)),
              rand_operand(), rand_operand());
      if (n % 200 == 100) cmd_queue[$].drain = 1'b1;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (cmd_queue.size() == 0 && !start_i);
    wait (result_queue.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("Issued %0d commands and checked %0d results; add %0d, mul %0d, div %0d,",
             issued, checked, cmd_count[fxalu_pkg::CmdAdd], cmd_count[fxalu_pkg::CmdMul],
             cmd_count[fxalu_pkg::CmdDiv]);
    $display("with extremes, all command codes, random bursts and full drains.");
    if (errors == 0 && result_queue.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
